// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-512 family package
// Round constants, initial hash words and the sequencer state type.
// ----------------------------------------------------------------------------
package sha512_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam int unsigned NumRounds = 80;

    localparam logic [1:0] VAR_512 = 2'd0;
    localparam logic [1:0] VAR_384 = 2'd1;
    localparam logic [1:0] VAR_224 = 2'd2;
    localparam logic [1:0] VAR_256 = 2'd3;

    localparam logic [63:0] ROUND_K [NumRounds] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };

    function automatic logic [63:0] init_word(input logic [1:0] v, input logic [2:0] i);
        logic [63:0] w;
        w = '0;
        unique case (v)
            VAR_512: case (i)
                3'd0: w = 64'h6A09E667F3BCC908; 3'd1: w = 64'hBB67AE8584CAA73B;
                3'd2: w = 64'h3C6EF372FE94F82B; 3'd3: w = 64'hA54FF53A5F1D36F1;
                3'd4: w = 64'h510E527FADE682D1; 3'd5: w = 64'h9B05688C2B3E6C1F;
                3'd6: w = 64'h1F83D9ABFB41BD6B; default: w = 64'h5BE0CD19137E2179;
            endcase
            VAR_384: case (i)
                3'd0: w = 64'hCBBB9D5DC1059ED8; 3'd1: w = 64'h629A292A367CD507;
                3'd2: w = 64'h9159015A3070DD17; 3'd3: w = 64'h152FECD8F70E5939;
                3'd4: w = 64'h67332667FFC00B31; 3'd5: w = 64'h8EB44A8768581511;
                3'd6: w = 64'hDB0C2E0D64F98FA7; default: w = 64'h47B5481DBEFA4FA4;
            endcase
            VAR_224: case (i)
                3'd0: w = 64'h8C3D37C819544DA2; 3'd1: w = 64'h73E1996689DCD4D6;
                3'd2: w = 64'h1DFAB7AE32FF9C82; 3'd3: w = 64'h679DD514582F9FCF;
                3'd4: w = 64'h0F6D2B697BD44DA8; 3'd5: w = 64'h77E36F7304C48942;
                3'd6: w = 64'h3F9D85A86A1D36C8; default: w = 64'h1112E6AD91D692A1;
            endcase
            default: case (i)
                3'd0: w = 64'h22312194FC2BF72C; 3'd1: w = 64'h9F555FA3C84C64C2;
                3'd2: w = 64'h2393B86B6F53B151; 3'd3: w = 64'h963877195940EABD;
                3'd4: w = 64'h96283EE2A88EFFE3; 3'd5: w = 64'hBE5E1E2553863992;
                3'd6: w = 64'h2B0199FC2C85B8AA; default: w = 64'h0EB72DDC81C52CA2;
            endcase
        endcase
        return w;
    endfunction

    // Index of the final digest word for each variant.
    function automatic logic [2:0] last_index(input logic [1:0] v);
        logic [2:0] n;
        unique case (v)
            VAR_512: n = 3'd7;
            VAR_384: n = 3'd5;
            default: n = 3'd3;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/sha512_family_hash.sv =====
// ----------------------------------------------------------------------------
// SHA-512 family hash
// Byte-serial SHA-512 / 384 / 512-224 / 512-256 with one shared round unit.
// ----------------------------------------------------------------------------
//
//  channel  | direction | signals
//  ---------+-----------+-----------------------------------------------
//  input    | in        | in_valid/in_ready, message_byte, has_byte, last_byte
//  output   | out       | out_valid/out_ready, digest_word, word_index, last_word
//  config   | in        | cfg_valid/cfg_ready, cfg_data (variant)
//
// A byte transfer that completes a 128-byte block starts the round unit, which
// runs 80 rounds and then folds the result into the hash words; no byte is
// taken until then. A final transfer pads one byte per cycle (up to 144
// bytes, one or two compressions) and then streams 4, 6 or 8 digest words,
// each waiting for out_ready. The single round unit, one round per cycle,
// sets the throughput. Reset loads the SHA-512 initial words. Configuration
// is taken only while idle and restarts the message.

module sha512_family_hash
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  message_byte,
    input  logic        has_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

`include "assert_macros.svh"

    state_t       state_reg, state_next;
    logic [1:0]   variant_reg;
    logic [63:0]  hash_reg [8];
    logic [63:0]  work_reg [8];
    logic [63:0]  sched_reg [16];
    logic [127:0] count_reg;
    logic [127:0] len_reg;       // message length in bits, updated at each transfer
    logic [6:0]   round_reg;
    logic [4:0]   pad_reg;       // padding phase: 0x80, zeros, then length byte number
    logic         finishing_reg; // the final transfer was taken; padding follows
    logic [2:0]   out_idx_reg;

    logic         in_fire, cfg_fire;
    logic [6:0]   pos;
    logic [7:0]   pad_byte;
    logic         pad_done_byte;
    logic [63:0]  w_cur, t1, t2, e, a;
    logic [63:0]  sx, sy, s0, s1;

    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign pos       = count_reg[9:3];

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Padding byte for the current position: 0x80 first, zeros, then length.
    always_comb
    begin
        pad_byte      = 8'h00;
        pad_done_byte = 1'b0;
        if (pad_reg == 5'd0)
        begin
            pad_byte = 8'h80;
        end
        else if (pad_reg >= 5'd2)
        begin
            pad_byte = len_reg[8'(127 - 8 * (pad_reg - 5'd2)) -: 8];
            pad_done_byte = (pad_reg == 5'd17);
        end
    end

    // Shared round unit.
    always_comb
    begin
        sx = sched_reg[4'(round_reg + 7'd14)];
        sy = sched_reg[4'(round_reg + 7'd1)];
        s1 = rotr(sx, 19) ^ rotr(sx, 61) ^ (sx >> 6);
        s0 = rotr(sy, 1) ^ rotr(sy, 8) ^ (sy >> 7);
        if (round_reg >= 7'd16)
            w_cur = sched_reg[round_reg[3:0]] + s1 + sched_reg[4'(round_reg + 7'd9)] + s0;
        else
            w_cur = sched_reg[round_reg[3:0]];
        e  = work_reg[4];
        a  = work_reg[0];
        t1 = work_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
             + ((e & work_reg[5]) ^ (~e & work_reg[6])) + ROUND_K[round_reg] + w_cur;
        t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
             + ((a & work_reg[1]) ^ (a & work_reg[2]) ^ (work_reg[1] & work_reg[2]));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_byte && pos == 7'd127)
                        state_next = ST_ROUND;
                    else if (last_byte)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (pos == 7'd127)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == 7'(NumRounds - 1))
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (finishing_reg && pad_reg == 5'd18)
                    state_next = ST_OUT;
                else if (finishing_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_ready && out_idx_reg == last_index(variant_reg))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid   = (state_reg == ST_OUT);
        word_index  = out_idx_reg;
        last_word   = (out_idx_reg == last_index(variant_reg));
        digest_word = hash_reg[out_idx_reg];
        if (variant_reg == VAR_224 && out_idx_reg == 3'd3)
            digest_word[31:0] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            variant_reg   <= VAR_512;
            count_reg     <= '0;
            round_reg     <= '0;
            pad_reg       <= '0;
            finishing_reg <= 1'b0;
            out_idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_word(VAR_512, 3'(i));
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        variant_reg <= cfg_data;
                        count_reg   <= '0;
                        for (int i = 0; i < 8; i++)
                            hash_reg[i] <= init_word(cfg_data, 3'(i));
                    end
                    else if (in_fire)
                    begin
                        finishing_reg <= last_byte;
                        pad_reg       <= '0;
                        out_idx_reg   <= '0;
                        if (has_byte)
                        begin
                            sched_reg[pos[6:3]][8'(63 - 8 * pos[2:0]) -: 8] <= message_byte;
                            count_reg <= count_reg + 128'd8;
                            len_reg   <= count_reg + 128'd8;
                        end
                        else
                        begin
                            len_reg <= count_reg;
                        end
                    end
                    for (int i = 0; i < 8; i++)
                        work_reg[i] <= hash_reg[i];
                end
                ST_PAD:
                begin
                    sched_reg[pos[6:3]][8'(63 - 8 * pos[2:0]) -: 8] <= pad_byte;
                    count_reg <= count_reg + 128'd8;
                    // Zeros run until the count is 896 mod 1024, then 16 length bytes.
                    if (pad_done_byte)
                        pad_reg <= 5'd18;
                    else if (pad_reg <= 5'd1 && pos == 7'd111)
                        pad_reg <= 5'd2;
                    else if (pad_reg != 5'd1)
                        pad_reg <= pad_reg + 5'd1;
                    for (int i = 0; i < 8; i++)
                        work_reg[i] <= hash_reg[i];
                end
                ST_ROUND:
                begin
                    sched_reg[round_reg[3:0]] <= w_cur;
                    work_reg[7] <= work_reg[6];
                    work_reg[6] <= work_reg[5];
                    work_reg[5] <= work_reg[4];
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[3] <= work_reg[2];
                    work_reg[2] <= work_reg[1];
                    work_reg[1] <= work_reg[0];
                    work_reg[0] <= t1 + t2;
                    round_reg   <= (round_reg == 7'(NumRounds - 1)) ? 7'd0 : round_reg + 7'd1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == last_index(variant_reg))
                        begin
                            count_reg <= '0;
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= init_word(variant_reg, 3'(i));
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_out_only_in_out, clk, rst_n, out_valid, !in_ready)
    `ASSERT_IMPLIES(a_round_range, clk, rst_n, state_reg == ST_ROUND, round_reg < 7'd80)
    `ASSERT_NEXT(a_round_after_full, clk, rst_n,
        in_fire && has_byte && pos == 7'd127, state_reg == ST_ROUND)
    `ASSERT_IMPLIES(a_no_cfg_busy, clk, rst_n, cfg_fire, state_reg == ST_IDLE && !in_fire)

endmodule
